// ===== src/prt_pkg.sv =====
package prt_pkg;

    // Largest prefix length the table can hold; host_bits above this is used as this.
    localparam logic [4:0] HB_MAX = 5'd16;

    typedef enum logic [1:0] {
        KIND_SET    = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_FIND   = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_INVALID   = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

    // One stored route, as it sits in the entry memory.
    typedef struct packed {
        logic [15:0] address;
        logic [4:0]  prefix;
        logic [7:0]  iface;
        logic [15:0] next_hop;
    } t_route;

    typedef struct packed {
        t_status     status;
        logic [5:0]  idx;
        t_route      route;
    } t_rsp;

endpackage

// ===== src/prt_if.sv =====
interface prt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] address;
    logic [4:0]  prefix_length;
    logic        iface_present;
    logic [7:0]  interface_id;
    logic [15:0] next_hop;
    logic [5:0]  start_index;

    modport source (
        output valid, kind, address, prefix_length, iface_present,
               interface_id, next_hop, start_index,
        input  ready
    );
    modport sink (
        input  valid, kind, address, prefix_length, iface_present,
               interface_id, next_hop, start_index,
        output ready
    );
endinterface

interface prt_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [5:0]  found_index;
    logic [15:0] found_address;
    logic [4:0]  found_prefix;
    logic [7:0]  found_interface;
    logic [15:0] found_next_hop;

    modport source (
        output valid, status, found_index, found_address, found_prefix,
               found_interface, found_next_hop,
        input  ready
    );
    modport sink (
        input  valid, status, found_index, found_address, found_prefix,
               found_interface, found_next_hop,
        output ready
    );
endinterface

// ===== src/prt_ram.sv =====
module prt_ram #(
    parameter int WIDTH = 45,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/prefix_route_table.sv =====
// Channel   Direction  Contents
// i_req     in         kind, address, prefix_length, iface_present, interface_id,
//                      next_hop, start_index
// o_rsp     out        status, found_index, found_address, found_prefix,
//                      found_interface, found_next_hop
// i_cfg_*   in         host_bits, written whenever i_cfg_we is high
//
// With n >= 1 used entries, a lookup reads all n entries and a set that has an interface
// reads them up to its exact entry; a valid find-previous from start index s reads entries
// s down to 0, stopping at a hit. Any other request goes to the finishing step unscanned.
// The memory's single registered read port feeds the compare unit one route per cycle.
// Reset (synchronous, active low) empties the table and sets host_bits to 14. A stalled
// response holds only the finishing step; a request is taken while a finished one waits.

module prefix_route_table #(
    parameter int ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    prt_req_if.sink     i_req,
    prt_rsp_if.source   o_rsp
);

    // Index width into the table and count width (the count can reach ENTRIES).
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    prt_pkg::t_state  r_state, n_state;

    // Request captured at its transfer. The prefix is stored already clamped.
    prt_pkg::t_kind   r_kind, n_kind;
    logic [15:0]      r_addr, n_addr;
    logic [4:0]       r_pfx, n_pfx;
    logic             r_has_if, n_has_if;
    logic [7:0]       r_ifc, n_ifc;
    logic [15:0]      r_via, n_via;

    // Scan sequencer: read address, reads still to issue, and the read in flight.
    logic [IW-1:0]    r_rd_idx, n_rd_idx;
    logic [CW-1:0]    r_left, n_left;
    logic             r_dv, n_dv;
    logic [IW-1:0]    r_chk_idx, n_chk_idx;

    // Find-previous key: the first entry read is the start entry itself.
    logic             r_key_vld, n_key_vld;
    logic [15:0]      r_key_addr, n_key_addr;
    logic [4:0]       r_key_pfx, n_key_pfx;

    // Best or first hit so far.
    logic             r_found, n_found;
    logic [4:0]       r_best_pfx, n_best_pfx;
    prt_pkg::t_route  r_res, n_res;
    logic [IW-1:0]    r_res_idx, n_res_idx;

    logic [CW-1:0]    r_count, n_count;
    logic [4:0]       r_host_bits, n_host_bits;

    logic             r_out_vld, n_out_vld;
    prt_pkg::t_rsp    r_out, n_out;

    logic             w_acc;
    logic             w_out_free;
    logic             w_go_scan;
    logic [4:0]       w_hb;
    logic [4:0]       w_in_pfx;
    prt_pkg::t_route  w_ent;
    logic [44:0]      w_rdata;
    logic             w_issue;
    logic             w_chk;
    logic [4:0]       w_shift;
    logic [15:0]      w_netmask;
    logic             w_match_set;
    logic             w_match_lk;
    logic             w_match_fp;
    logic             w_stop;
    logic             w_scan_end;
    logic             w_fin;
    logic             w_room;
    logic             w_we;
    logic [IW-1:0]    w_waddr;
    prt_pkg::t_route  w_wdata;

    // Effective host bits: values above sixteen behave as sixteen.
    assign w_hb     = (r_host_bits > prt_pkg::HB_MAX) ? prt_pkg::HB_MAX : r_host_bits;
    assign w_in_pfx = (i_req.prefix_length > w_hb) ? w_hb : i_req.prefix_length;

    assign w_acc      = i_req.valid && i_req.ready;
    assign w_out_free = !r_out_vld || o_rsp.ready;

    // A request scans only when there is at least one entry to look at.
    always_comb begin
        case (prt_pkg::t_kind'(i_req.kind))
            prt_pkg::KIND_SET:    w_go_scan = i_req.iface_present && (r_count != '0);
            prt_pkg::KIND_LOOKUP: w_go_scan = (r_count != '0);
            prt_pkg::KIND_FIND:   w_go_scan = (i_req.start_index != 6'd0) &&
                                              (7'(i_req.start_index) < 7'(r_count));
            default:              w_go_scan = 1'b0;
        endcase
    end

    // Shared compare unit. It sees one stored entry per cycle, in the cycle after its
    // address went to the memory.
    assign w_ent   = prt_pkg::t_route'(w_rdata);
    assign w_issue = (r_state == prt_pkg::ST_SCAN) && (r_left != '0);
    assign w_chk   = (r_state == prt_pkg::ST_SCAN) && r_dv;

    // A stored prefix above the current host bits demands a match of the whole address.
    assign w_shift   = (w_ent.prefix <= w_hb) ? (w_hb - w_ent.prefix) : 5'd0;
    assign w_netmask = ~(16'(17'd1 << w_shift) - 16'd1);

    assign w_match_set = (w_ent.address == r_addr) && (w_ent.prefix == r_pfx) &&
                         (w_ent.iface == r_ifc);
    assign w_match_lk  = ((w_ent.address & w_netmask) == (r_addr & w_netmask)) &&
                         (w_ent.prefix >= r_best_pfx);
    assign w_match_fp  = !r_key_vld && (w_ent.prefix == r_key_pfx) &&
                         (w_ent.address == r_key_addr);

    // Set and find-previous stop at their first hit; a lookup runs to the end.
    assign w_stop     = w_chk && (((r_kind == prt_pkg::KIND_SET) && w_match_set) ||
                                  ((r_kind == prt_pkg::KIND_FIND) && w_match_fp));
    assign w_scan_end = w_stop || (w_chk && (r_left == '0));

    assign w_room = (r_count < CW'(ENTRIES));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            prt_pkg::ST_IDLE: begin
                if (w_acc) begin
                    n_state = w_go_scan ? prt_pkg::ST_SCAN : prt_pkg::ST_FIN;
                end
            end
            prt_pkg::ST_SCAN: begin
                if (w_scan_end) begin
                    n_state = prt_pkg::ST_FIN;
                end
            end
            prt_pkg::ST_FIN: begin
                if (w_out_free) begin
                    n_state = prt_pkg::ST_IDLE;
                end
            end
            default: n_state = prt_pkg::ST_IDLE;
        endcase
    end

    // State machine outputs: request ready, finishing step and the memory write.
    // A set with an interface writes its entry in the finishing step, either over
    // the exact match or appended behind the used entries when there is room.
    always_comb begin
        i_req.ready = (r_state == prt_pkg::ST_IDLE);
        w_fin       = (r_state == prt_pkg::ST_FIN) && w_out_free;
        w_we        = w_fin && (r_kind == prt_pkg::KIND_SET) && r_has_if &&
                      (r_found || w_room);
        w_waddr     = r_found ? r_res_idx : IW'(r_count);
        w_wdata.address  = r_addr;
        w_wdata.prefix   = r_pfx;
        w_wdata.iface    = r_ifc;
        w_wdata.next_hop = r_via;
    end

    // Datapath next values.
    always_comb begin
        n_kind      = r_kind;
        n_addr      = r_addr;
        n_pfx       = r_pfx;
        n_has_if    = r_has_if;
        n_ifc       = r_ifc;
        n_via       = r_via;
        n_rd_idx    = r_rd_idx;
        n_left      = r_left;
        n_dv        = w_issue;
        n_chk_idx   = r_rd_idx;
        n_key_vld   = r_key_vld;
        n_key_addr  = r_key_addr;
        n_key_pfx   = r_key_pfx;
        n_found     = r_found;
        n_best_pfx  = r_best_pfx;
        n_res       = r_res;
        n_res_idx   = r_res_idx;
        n_count     = r_count;
        n_host_bits = i_cfg_we ? i_cfg_wdata : r_host_bits;
        n_out_vld   = r_out_vld && !o_rsp.ready;
        n_out       = r_out;

        if (w_acc) begin
            n_kind     = prt_pkg::t_kind'(i_req.kind);
            n_addr     = i_req.address;
            n_pfx      = w_in_pfx;
            n_has_if   = i_req.iface_present;
            n_ifc      = i_req.interface_id;
            n_via      = i_req.next_hop;
            n_dv       = 1'b0;
            n_key_vld  = 1'b1;
            n_found    = 1'b0;
            n_best_pfx = 5'd0;
            // Find-previous reads the start entry first, then walks down to entry 0.
            if (prt_pkg::t_kind'(i_req.kind) == prt_pkg::KIND_FIND) begin
                n_rd_idx = IW'(i_req.start_index);
                n_left   = CW'(i_req.start_index) + CW'(1);
            end else begin
                n_rd_idx = '0;
                n_left   = r_count;
            end
            if (prt_pkg::t_kind'(i_req.kind) == prt_pkg::KIND_CLEAR) begin
                n_count = '0;
            end
        end

        if (w_issue) begin
            n_left   = r_left - CW'(1);
            n_rd_idx = (r_kind == prt_pkg::KIND_FIND) ? (r_rd_idx - IW'(1))
                                                      : (r_rd_idx + IW'(1));
        end

        if (w_chk) begin
            case (r_kind)
                prt_pkg::KIND_SET: begin
                    if (w_match_set) begin
                        n_found   = 1'b1;
                        n_res_idx = r_chk_idx;
                    end
                end
                prt_pkg::KIND_LOOKUP: begin
                    // Later entries win ties, hence the compare with equality.
                    if (w_match_lk) begin
                        n_found    = 1'b1;
                        n_best_pfx = w_ent.prefix;
                        n_res      = w_ent;
                        n_res_idx  = r_chk_idx;
                    end
                end
                prt_pkg::KIND_FIND: begin
                    if (r_key_vld) begin
                        n_key_vld  = 1'b0;
                        n_key_addr = w_ent.address;
                        n_key_pfx  = w_ent.prefix;
                    end else if (w_match_fp) begin
                        n_found   = 1'b1;
                        n_res     = w_ent;
                        n_res_idx = r_chk_idx;
                    end
                end
                default: begin
                end
            endcase
        end

        // Finishing step: build the response. Every field except the status is zero
        // unless the status is ok, and a clear answers with all zeros.
        if (w_fin) begin
            n_out_vld = 1'b1;
            n_out     = '0;
            case (r_kind)
                prt_pkg::KIND_SET: begin
                    if (!r_has_if) begin
                        n_out.status = prt_pkg::STAT_INVALID;
                    end else if (!r_found && !w_room) begin
                        n_out.status = prt_pkg::STAT_FULL;
                    end else begin
                        n_out.status = prt_pkg::STAT_OK;
                        n_out.idx    = 6'(w_waddr);
                        n_out.route  = w_wdata;
                        if (!r_found) begin
                            n_count = r_count + CW'(1);
                        end
                    end
                end
                prt_pkg::KIND_LOOKUP, prt_pkg::KIND_FIND: begin
                    if (r_found) begin
                        n_out.status = prt_pkg::STAT_OK;
                        n_out.idx    = 6'(r_res_idx);
                        n_out.route  = r_res;
                    end else begin
                        n_out.status = prt_pkg::STAT_NOT_FOUND;
                    end
                end
                default: begin
                    n_out.status = prt_pkg::STAT_OK;
                end
            endcase
        end
    end

    // Control state is reset; captured request and result fields are payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= prt_pkg::ST_IDLE;
            r_left      <= '0;
            r_dv        <= 1'b0;
            r_count     <= '0;
            r_host_bits <= 5'd14;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_left      <= n_left;
            r_dv        <= n_dv;
            r_count     <= n_count;
            r_host_bits <= n_host_bits;
            r_out_vld   <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_addr     <= n_addr;
        r_pfx      <= n_pfx;
        r_has_if   <= n_has_if;
        r_ifc      <= n_ifc;
        r_via      <= n_via;
        r_rd_idx   <= n_rd_idx;
        r_chk_idx  <= n_chk_idx;
        r_key_vld  <= n_key_vld;
        r_key_addr <= n_key_addr;
        r_key_pfx  <= n_key_pfx;
        r_found    <= n_found;
        r_best_pfx <= n_best_pfx;
        r_res      <= n_res;
        r_res_idx  <= n_res_idx;
        r_out      <= n_out;
    end

    // Route storage: one write port for set, one registered read port for the scan.
    prt_ram #(
        .WIDTH ($bits(prt_pkg::t_route)),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_rd_idx),
        .o_rdata (w_rdata)
    );

    assign o_rsp.valid           = r_out_vld;
    assign o_rsp.status          = r_out.status;
    assign o_rsp.found_index     = r_out.idx;
    assign o_rsp.found_address   = r_out.route.address;
    assign o_rsp.found_prefix    = r_out.route.prefix;
    assign o_rsp.found_interface = r_out.route.iface;
    assign o_rsp.found_next_hop  = r_out.route.next_hop;

endmodule
